// ===== rtl/row_activation_tracker_defines.svh =====
// Assertion macros shared by the row activation tracker RTL.
`ifndef ROW_ACTIVATION_TRACKER_DEFINES_SVH
`define ROW_ACTIVATION_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define RAT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("row activation tracker check failed");
`define RAT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("row activation tracker check failed");
`else
`define RAT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define RAT_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rat_pkg.sv =====
// Types, constants and helper functions of the row activation tracker.
`default_nettype none
package rat_pkg;
	localparam int NUM_RANKS       = 2;
	localparam int NUM_GROUPS      = 4;
	localparam int BANKS_PER_GROUP = 4;
	localparam int TABLE_ENTRIES   = 8;
	localparam int ROW_BITS        = 16;
	localparam int COUNT_BITS      = 24;

	localparam int BANK_COUNT = NUM_RANKS * NUM_GROUPS * BANKS_PER_GROUP;
	localparam int BANK_BITS  = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int SLOT_BITS  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD    = 1'd1;

	localparam logic [COUNT_BITS-1:0] THRESHOLD_RESET = COUNT_BITS'(1000);
	localparam logic [31:0]           PERIOD_RESET    = 32'd1000000;

	typedef struct packed {
		logic                  valid;
		logic [ROW_BITS-1:0]   tag;
		logic [COUNT_BITS-1:0] count;
	} slot_t;

	typedef struct packed {
		slot_t [TABLE_ENTRIES-1:0] slots;
		logic [COUNT_BITS-1:0]     spill;
	} bank_row_t;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_BITS-1:0] hit_idx;
		logic                 victim;
		logic [SLOT_BITS-1:0] victim_idx;
	} search_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
	endfunction

	function automatic logic [BANK_BITS-1:0] bank_flat(input logic [0:0] rank,
			input logic [1:0] group, input logic [1:0] bank);
		int v;
		v = (int'(rank) * NUM_GROUPS + int'(group)) * BANKS_PER_GROUP + int'(bank);
		return BANK_BITS'(v);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/rat_act_if.sv =====
// Channel that carries one controller tick with an optional row activation.
`default_nettype none
interface rat_act_if;
	logic        valid;
	logic        ready;
	logic        is_activate;
	logic [0:0]  rank_index;
	logic [1:0]  group_index;
	logic [1:0]  bank_index;
	logic [15:0] row_address;

	modport source(output valid, is_activate, rank_index, group_index, bank_index,
		row_address, input ready);
	modport sink(input valid, is_activate, rank_index, group_index, bank_index,
		row_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/rat_ref_if.sv =====
// Channel that carries one victim refresh decision per tick.
`default_nettype none
interface rat_ref_if;
	logic        valid;
	logic        ready;
	logic        refresh_needed;
	logic [0:0]  refresh_rank;
	logic [1:0]  refresh_group;
	logic [1:0]  refresh_bank;
	logic [15:0] refresh_row;

	modport source(output valid, refresh_needed, refresh_rank, refresh_group, refresh_bank,
		refresh_row, input ready);
	modport sink(input valid, refresh_needed, refresh_rank, refresh_group, refresh_bank,
		refresh_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/row_activation_tracker.sv =====
// Top level of the row activation tracker.
//
// Channel   Dir  Payload
// act       in   is_activate, rank_index, group_index, bank_index, row_address
// refresh   out  refresh_needed, refresh_rank, refresh_group, refresh_bank, refresh_row
//
// Each transfer on act passes through three steps: the bank's table row is read from the
// table memory, then searched, then updated and written back through its one write port.
// A finished result waits in the output register while the next transfer is taken in;
// that item's update holds until the output register is free.
// Reset needs no clearing pass: per-bank written and stale flags mask the memory contents.
`default_nettype none
`include "row_activation_tracker_defines.svh"
module row_activation_tracker import rat_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
	rat_act_if.sink                       act,
	rat_ref_if.source                     refresh
);
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam int ROW_WORD_BITS = $bits(bank_row_t);

	logic [1:0]            state_q;
	logic [COUNT_BITS-1:0] thr_q;
	logic [31:0]           period_q;
	logic [31:0]           tick_q;
	logic [BANK_COUNT-1:0] stale_q;
	logic [BANK_COUNT-1:0] written_q;

	logic                  act_ok_q;
	logic [BANK_BITS-1:0]  bank_q;
	logic [0:0]            rank_q;
	logic [1:0]            group_q;
	logic [1:0]            bnk_q;
	logic [ROW_BITS-1:0]   row_q;

	bank_row_t row_s2;
	search_t   srch_s2;

	logic        out_valid_q;
	logic        out_needed_q;
	logic [0:0]  out_rank_q;
	logic [1:0]  out_group_q;
	logic [1:0]  out_bank_q;
	logic [15:0] out_row_q;

	logic                     accept;
	logic                     out_free;
	logic                     finish;
	logic                     ram_we;
	logic [BANK_BITS-1:0]     rd_bank;
	logic [ROW_WORD_BITS-1:0] ram_rdata;
	bank_row_t                rd_row;
	bank_row_t                masked_row;
	search_t                  srch;
	bank_row_t                upd_row;
	logic                     hit_refresh;
	logic [COUNT_BITS-1:0]    cnt_inc;
	logic [32:0]              tick_nxt;
	logic                     in_range;

	assign act.ready = (state_q == ST_IDLE);
	assign accept    = act.valid && act.ready;
	assign out_free  = !out_valid_q || refresh.ready;
	assign finish    = (state_q == ST_UPDATE) && out_free;
	assign ram_we    = finish && act_ok_q;
	assign rd_bank   = bank_flat(act.rank_index, act.group_index, act.bank_index);
	assign tick_nxt  = {1'b0, tick_q} + 33'd1;
	assign in_range  = (32'(act.rank_index) < 32'(NUM_RANKS))
		&& (32'(act.group_index) < 32'(NUM_GROUPS))
		&& (32'(act.bank_index) < 32'(BANKS_PER_GROUP));

	rat_ram #(
		.WIDTH(ROW_WORD_BITS),
		.DEPTH(BANK_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(bank_q),
		.wdata(upd_row),
		.re   (accept),
		.raddr(rd_bank),
		.rdata(ram_rdata)
	);

	always_comb begin
		rd_row     = bank_row_t'(ram_rdata);
		masked_row = rd_row;
		if (!written_q[bank_q]) begin
			masked_row = '0;
		end else if (stale_q[bank_q]) begin
			masked_row.spill = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				masked_row.slots[i].count = '0;
			end
		end
	end

	rat_search u_search (
		.row(masked_row),
		.tag(row_q),
		.res(srch)
	);

	always_comb begin
		upd_row     = row_s2;
		hit_refresh = 1'b0;
		cnt_inc     = sat_inc(row_s2.slots[srch_s2.hit_idx].count);
		if (srch_s2.hit) begin
			if (cnt_inc >= thr_q) begin
				hit_refresh = act_ok_q;
				upd_row.slots[srch_s2.hit_idx].count = row_s2.spill;
			end else begin
				upd_row.slots[srch_s2.hit_idx].count = cnt_inc;
			end
		end else if (srch_s2.victim) begin
			upd_row.slots[srch_s2.victim_idx].valid = 1'b1;
			upd_row.slots[srch_s2.victim_idx].tag   = row_q;
			upd_row.slots[srch_s2.victim_idx].count = sat_inc(row_s2.spill);
		end else begin
			upd_row.spill = sat_inc(row_s2.spill);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THRESHOLD_RESET;
			period_q    <= PERIOD_RESET;
			tick_q      <= '0;
			stale_q     <= '0;
			written_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr_q <= cfg_wdata[COUNT_BITS-1:0];
					REG_PERIOD:    period_q <= cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (refresh.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SEARCH;
						tick_q  <= (tick_nxt >= {1'b0, period_q}) ? '0 : tick_nxt[31:0];
						if (tick_q == '0) begin
							stale_q <= '1;
						end
					end
				end
				ST_SEARCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (act_ok_q) begin
							stale_q[bank_q]   <= 1'b0;
							written_q[bank_q] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_ok_q <= act.is_activate && in_range;
			bank_q   <= rd_bank;
			rank_q   <= act.rank_index;
			group_q  <= act.group_index;
			bnk_q    <= act.bank_index;
			row_q    <= act.row_address[ROW_BITS-1:0];
		end
		if (state_q == ST_SEARCH) begin
			row_s2  <= masked_row;
			srch_s2 <= srch;
		end
		if (finish) begin
			out_needed_q <= hit_refresh;
			out_rank_q   <= hit_refresh ? rank_q : '0;
			out_group_q  <= hit_refresh ? group_q : '0;
			out_bank_q   <= hit_refresh ? bnk_q : '0;
			out_row_q    <= hit_refresh ? 16'(row_q) : '0;
		end
	end

	assign refresh.valid          = out_valid_q;
	assign refresh.refresh_needed = out_needed_q;
	assign refresh.refresh_rank   = out_rank_q;
	assign refresh.refresh_group  = out_group_q;
	assign refresh.refresh_bank   = out_bank_q;
	assign refresh.refresh_row    = out_row_q;

	// A transfer on the input starts the table search in the following cycle.
	`RAT_ASSERT_NXT(a_accept_to_search, clk, arst_n, accept, state_q == ST_SEARCH)
	// A written-back bank row is marked current and initialized.
	`RAT_ASSERT_NXT(a_writeback_marks, clk, arst_n, ram_we, written_q[bank_q] && !stale_q[bank_q])
	// A result without a refresh request carries an all-zero aggressor address.
	`RAT_ASSERT_IMP(a_zero_fields, clk, arst_n, refresh.valid && !refresh.refresh_needed, refresh.refresh_row == 16'd0 && refresh.refresh_rank == 1'b0 && refresh.refresh_group == 2'd0 && refresh.refresh_bank == 2'd0)
endmodule
`default_nettype wire

// ===== rtl/rat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rat_ram #(
	parameter int WIDTH     = 8,
	parameter int DEPTH     = 32,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [ADDR_BITS-1:0]  waddr,
	input  wire logic [WIDTH-1:0]      wdata,
	input  wire logic                  re,
	input  wire logic [ADDR_BITS-1:0]  raddr,
	output      logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/rat_search.sv =====
// Tag match and replacement slot search over one bank's table row.
`default_nettype none
module rat_search import rat_pkg::*; (
	input  wire bank_row_t           row,
	input  wire logic [ROW_BITS-1:0] tag,
	output      search_t             res
);
	always_comb begin
		res = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (!res.hit && row.slots[i].valid && row.slots[i].tag == tag) begin
				res.hit     = 1'b1;
				res.hit_idx = SLOT_BITS'(i);
			end
			if (!res.victim && row.slots[i].count == row.spill) begin
				res.victim     = 1'b1;
				res.victim_idx = SLOT_BITS'(i);
			end
		end
	end
endmodule
`default_nettype wire
